/* hdl/bce_pkg.sv */
// ----------------------------------------------------------------------------
// bce_pkg
// Shared widths, codes and types of the box cut efficiency block.
// ----------------------------------------------------------------------------
package bce_pkg;

    localparam int FEATURES         = 5;
    localparam int FEATURE_BITS     = 12;
    localparam int WEIGHT_BITS      = 32;
    localparam int EVENT_COUNT_BITS = 20;
    localparam int ACC_BITS         = WEIGHT_BITS + EVENT_COUNT_BITS;
    localparam int BOUND_BITS       = FEATURES * FEATURE_BITS;
    localparam int ACTIVE_BITS      = 3;
    localparam int XS_BITS          = 32;
    localparam int FRAC_BITS        = 16;
    localparam int EFF_BITS         = FRAC_BITS + 1;
    localparam int IMP_BITS         = 24;
    localparam int STATUS_BITS      = 2;

    // APB side
    localparam int ADDR_BITS = 6;
    localparam int DATA_BITS = 64;

    // Arithmetic widths of the final computation
    localparam int UNIT_BITS  = ACC_BITS + 1;
    localparam int REM_BITS   = 2 * FRAC_BITS + EFF_BITS + 1;
    localparam int BASE_BITS  = XS_BITS + 1 + FRAC_BITS;
    localparam int SQ_BITS    = 48;
    localparam int Q_BITS     = SQ_BITS + 1;
    localparam int A_BITS     = 2 * FRAC_BITS + 1;
    localparam int MUL_B_BITS = 32;
    localparam int MUL_P_BITS = A_BITS + MUL_B_BITS;
    localparam int HI_BITS    = BASE_BITS - MUL_B_BITS;
    localparam int PROD_BITS  = A_BITS + BASE_BITS;
    localparam int ROOT_BITS  = SQ_BITS / 2;
    localparam int STEP_BITS  = 7;

    localparam int RATIO_STEPS = EFF_BITS;
    localparam int DIV_STEPS   = PROD_BITS;
    localparam int SQRT_STEPS  = ROOT_BITS;

    localparam logic [ACTIVE_BITS-1:0] REG_LOWER  = 3'd0;
    localparam logic [ACTIVE_BITS-1:0] REG_UPPER  = 3'd1;
    localparam logic [ACTIVE_BITS-1:0] REG_ACTIVE = 3'd2;
    localparam logic [ACTIVE_BITS-1:0] REG_PHOTON = 3'd3;
    localparam logic [ACTIVE_BITS-1:0] REG_DIS    = 3'd4;

    localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_ZERO_DEN = 2'd2;

    localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 3'd5;
    localparam logic [XS_BITS-1:0]     XS_RESET     = 32'd65536;
    localparam logic [IMP_BITS-1:0]    IMPROVE_MAX  = {IMP_BITS{1'b1}};

    typedef logic signed [FEATURE_BITS-1:0] feature_t;
    typedef logic [ACC_BITS-1:0]            acc_t;

    typedef struct packed {
        logic                   is_signal;
        feature_t               feature_a;
        feature_t               feature_b;
        feature_t               feature_c;
        feature_t               feature_d;
        feature_t               feature_e;
        logic [WEIGHT_BITS-1:0] event_weight;
        logic                   is_last;
    } event_t;

    typedef struct packed {
        logic [EFF_BITS-1:0]    signal_efficiency;
        logic [EFF_BITS-1:0]    background_efficiency;
        logic [IMP_BITS-1:0]    improvement;
        logic [STATUS_BITS-1:0] status;
    } result_t;

    typedef struct packed {
        logic [BOUND_BITS-1:0]  lower_bounds;
        logic [BOUND_BITS-1:0]  upper_bounds;
        logic [ACTIVE_BITS-1:0] active_features;
    } box_cfg_t;

    typedef struct packed {
        acc_t signal_sum;
        acc_t signal_passed_sum;
        acc_t background_sum;
        acc_t background_passed_sum;
    } sums_t;

    typedef struct packed {
        logic start;
        logic ack;
    } calc_ctrl_t;

    typedef enum logic [3:0] {
        CALC_IDLE,
        CALC_CHECK,
        CALC_RAT_S,
        CALC_RAT_B,
        CALC_MUL_ES,
        CALC_MUL_PE,
        CALC_REM,
        CALC_MUL_LO,
        CALC_MUL_HI,
        CALC_SUM,
        CALC_DIV,
        CALC_SQRT,
        CALC_DONE
    } calc_state_t;

endpackage

/* hdl/box_cut_efficiency.sv */
// ----------------------------------------------------------------------------
// box_cut_efficiency: box cut efficiencies and improvement over weighted events
// Throughput: an event without the last mark is taken every cycle while no
//   result is pending; after a last event the divide steps (82) and root
//   steps (24) of one shared compare-subtract unit run, all skipped for an
//   empty class, and no event is taken meanwhile.
// Reset: rst_n clears sums and control at once; registers return to defaults.
// ----------------------------------------------------------------------------
module box_cut_efficiency
    import bce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    input  logic                 event_valid,
    output logic                 event_ready,
    input  event_t               event_data,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result_data
);

    logic [BOUND_BITS-1:0]  lower_bounds_reg;
    logic [BOUND_BITS-1:0]  upper_bounds_reg;
    logic [ACTIVE_BITS-1:0] active_features_reg;
    logic [XS_BITS-1:0]     photon_reg;
    logic [XS_BITS-1:0]     dis_reg;

    logic                   busy_reg;
    logic                   start_reg;
    logic                   out_valid_reg;
    result_t                out_data_reg;

    logic [ACTIVE_BITS-1:0] reg_index;
    logic                   cfg_write;
    logic                   accept;
    logic                   out_load;
    logic                   calc_done;
    result_t                calc_result;
    calc_ctrl_t             calc_ctrl;
    box_cfg_t               box_cfg;
    sums_t                  sums;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_BITS-1 -: ACTIVE_BITS];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_bounds_reg    <= '0;
            upper_bounds_reg    <= '0;
            active_features_reg <= ACTIVE_RESET;
            photon_reg          <= XS_RESET;
            dis_reg             <= XS_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_LOWER:  lower_bounds_reg    <= pwdata[BOUND_BITS-1:0];
                REG_UPPER:  upper_bounds_reg    <= pwdata[BOUND_BITS-1:0];
                REG_ACTIVE: active_features_reg <= pwdata[ACTIVE_BITS-1:0];
                REG_PHOTON: photon_reg          <= pwdata[XS_BITS-1:0];
                REG_DIS:    dis_reg             <= pwdata[XS_BITS-1:0];
                default:    dis_reg             <= dis_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_LOWER:  prdata = DATA_BITS'(lower_bounds_reg);
            REG_UPPER:  prdata = DATA_BITS'(upper_bounds_reg);
            REG_ACTIVE: prdata = DATA_BITS'(active_features_reg);
            REG_PHOTON: prdata = DATA_BITS'(photon_reg);
            REG_DIS:    prdata = DATA_BITS'(dis_reg);
            default:    prdata = '0;
        endcase
    end

    assign box_cfg.lower_bounds    = lower_bounds_reg;
    assign box_cfg.upper_bounds    = upper_bounds_reg;
    assign box_cfg.active_features = active_features_reg;

    assign event_ready = !busy_reg;
    assign accept      = event_valid && event_ready;
    // hand a finished result over only when the output slot is free
    assign out_load    = calc_done && (!out_valid_reg || result_ready);

    assign calc_ctrl.start = start_reg;
    assign calc_ctrl.ack   = out_load;

    bce_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_cfg    (box_cfg),
        .event_data (event_data),
        .update     (accept),
        .clear      (out_load),
        .sums       (sums)
    );

    bce_calc u_calc (
        .clk                  (clk),
        .rst_n                (rst_n),
        .ctrl                 (calc_ctrl),
        .sums                 (sums),
        .photon_cross_section (photon_reg),
        .dis_cross_section    (dis_reg),
        .done                 (calc_done),
        .result               (calc_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= accept && event_data.is_last;
            if (accept && event_data.is_last)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_load)
            begin
                busy_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= calc_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (sums == '0))
        else $error("sums not cleared after a result");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        calc_done |-> busy_reg)
        else $error("result finished without a pending last event");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.status == STATUS_EMPTY) |->
        (result_data.signal_efficiency == '0 && result_data.background_efficiency == '0 &&
         result_data.improvement == '0))
        else $error("empty class result carries nonzero fields");

    a_eff_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
        (result_data.signal_efficiency <= EFF_BITS'(65536) &&
         result_data.background_efficiency <= EFF_BITS'(65536)))
        else $error("efficiency above one");
`endif

endmodule

/* hdl/bce_accum.sv */
// ----------------------------------------------------------------------------
// bce_accum
// Box test of the leading features and saturating class sums.
// ----------------------------------------------------------------------------
module bce_accum
    import bce_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  box_cfg_t box_cfg,
    input  event_t   event_data,
    input  logic     update,
    input  logic     clear,
    output sums_t    sums
);

    feature_t               feat [FEATURES];
    logic [ACTIVE_BITS-1:0] tested;
    logic                   pass;
    sums_t                  sums_reg;
    sums_t                  sums_next;

    function automatic acc_t sat_add(input acc_t acc, input logic [WEIGHT_BITS-1:0] w);
        logic [ACC_BITS:0] s;
        s = {1'b0, acc} + (ACC_BITS + 1)'(w);
        return s[ACC_BITS] ? {ACC_BITS{1'b1}} : s[ACC_BITS-1:0];
    endfunction

    always_comb
    begin
        feat[0] = event_data.feature_a;
        feat[1] = event_data.feature_b;
        feat[2] = event_data.feature_c;
        feat[3] = event_data.feature_d;
        feat[4] = event_data.feature_e;
    end

    assign tested = (box_cfg.active_features > ACTIVE_BITS'(FEATURES))
                    ? ACTIVE_BITS'(FEATURES) : box_cfg.active_features;

    always_comb
    begin
        pass = 1'b1;
        for (int i = 0; i < FEATURES; i++)
        begin
            if (ACTIVE_BITS'(i) < tested &&
                (feat[i] < signed'(box_cfg.lower_bounds[i*FEATURE_BITS +: FEATURE_BITS]) ||
                 feat[i] > signed'(box_cfg.upper_bounds[i*FEATURE_BITS +: FEATURE_BITS])))
            begin
                pass = 1'b0;
            end
        end
    end

    always_comb
    begin
        sums_next = sums_reg;
        if (clear)
        begin
            sums_next = '0;
        end
        else if (update)
        begin
            if (event_data.is_signal)
            begin
                sums_next.signal_sum = sat_add(sums_reg.signal_sum, event_data.event_weight);
                if (pass)
                begin
                    sums_next.signal_passed_sum =
                        sat_add(sums_reg.signal_passed_sum, event_data.event_weight);
                end
            end
            else
            begin
                sums_next.background_sum =
                    sat_add(sums_reg.background_sum, event_data.event_weight);
                if (pass)
                begin
                    sums_next.background_passed_sum =
                        sat_add(sums_reg.background_passed_sum, event_data.event_weight);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_reg <= '0;
        end
        else
        begin
            sums_reg <= sums_next;
        end
    end

    assign sums = sums_reg;

endmodule

/* hdl/bce_unit.sv */
// ----------------------------------------------------------------------------
// bce_unit
// Shared compare and subtract step for division and square root.
// ----------------------------------------------------------------------------
module bce_unit
    import bce_pkg::*;
(
    input  logic [UNIT_BITS-1:0] x,
    input  logic [UNIT_BITS-1:0] y,
    output logic                 ge,
    output logic [UNIT_BITS-1:0] diff
);

    assign ge   = (x >= y);
    assign diff = x - y;

endmodule

/* hdl/bce_calc.sv */
// ----------------------------------------------------------------------------
// bce_calc
// Sequencer for efficiencies, scaled ratio and square root of the result.
// ----------------------------------------------------------------------------
module bce_calc
    import bce_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  calc_ctrl_t         ctrl,
    input  sums_t              sums,
    input  logic [XS_BITS-1:0] photon_cross_section,
    input  logic [XS_BITS-1:0] dis_cross_section,
    output logic               done,
    output result_t            result
);

    calc_state_t state_reg;
    calc_state_t state_next;
    logic [STEP_BITS-1:0] cnt_reg;
    logic [STEP_BITS-1:0] cnt_next;

    logic [UNIT_BITS-1:0]   r_reg;
    logic [Q_BITS-1:0]      q_reg;
    logic                   sat_reg;
    logic [EFF_BITS-1:0]    es_reg;
    logic [EFF_BITS-1:0]    eb_reg;
    logic [IMP_BITS-1:0]    imp_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [A_BITS-1:0]      a_reg;
    logic [REM_BITS-1:0]    rem_reg;
    logic [BASE_BITS-1:0]   base_reg;
    logic [MUL_P_BITS-1:0]  mul_reg;
    logic [PROD_BITS-1:0]   prod_reg;

    logic [UNIT_BITS-1:0]  unit_x;
    logic [UNIT_BITS-1:0]  unit_y;
    logic                  unit_ge;
    logic [UNIT_BITS-1:0]  unit_diff;
    logic [UNIT_BITS-1:0]  r_next;
    logic [Q_BITS-1:0]     q_shift;
    logic                  sat_next;
    logic [A_BITS-1:0]     mul_a;
    logic [MUL_B_BITS-1:0] mul_b;
    logic [MUL_P_BITS-1:0] mul_p;
    logic                  last_step;
    logic                  empty;
    logic                  rem_zero;
    acc_t                  num;
    acc_t                  den;

    bce_unit u_unit (
        .x    (unit_x),
        .y    (unit_y),
        .ge   (unit_ge),
        .diff (unit_diff)
    );

    assign empty    = (sums.signal_sum == '0) || (sums.background_sum == '0);
    assign rem_zero = (rem_reg == '0);
    assign r_next   = unit_ge ? unit_diff : unit_x;
    assign q_shift  = {q_reg[Q_BITS-2:0], unit_ge};
    // quotient is a prefix of the final one: once past the limit, stay saturated
    assign sat_next = sat_reg | q_reg[Q_BITS-1] | q_shift[Q_BITS-1];
    assign mul_p    = MUL_P_BITS'(mul_a) * MUL_P_BITS'(mul_b);

    always_comb
    begin
        case (state_reg)
            CALC_RAT_S, CALC_RAT_B: last_step = (cnt_reg == STEP_BITS'(RATIO_STEPS - 1));
            CALC_DIV:               last_step = (cnt_reg == STEP_BITS'(DIV_STEPS - 1));
            CALC_SQRT:              last_step = (cnt_reg == STEP_BITS'(SQRT_STEPS - 1));
            default:                last_step = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CALC_IDLE:   if (ctrl.start) state_next = CALC_CHECK;
            CALC_CHECK:  state_next = empty ? CALC_DONE : CALC_RAT_S;
            CALC_RAT_S:  if (last_step) state_next = CALC_RAT_B;
            CALC_RAT_B:  if (last_step) state_next = CALC_MUL_ES;
            CALC_MUL_ES: state_next = CALC_MUL_PE;
            CALC_MUL_PE: state_next = CALC_REM;
            CALC_REM:    state_next = CALC_MUL_LO;
            CALC_MUL_LO: state_next = rem_zero ? CALC_DONE : CALC_MUL_HI;
            CALC_MUL_HI: state_next = CALC_SUM;
            CALC_SUM:    state_next = CALC_DIV;
            CALC_DIV:    if (last_step) state_next = sat_next ? CALC_DONE : CALC_SQRT;
            CALC_SQRT:   if (last_step) state_next = CALC_DONE;
            CALC_DONE:   if (ctrl.ack) state_next = CALC_IDLE;
            default:     state_next = CALC_IDLE;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            CALC_RAT_S, CALC_RAT_B, CALC_DIV, CALC_SQRT:
                cnt_next = last_step ? '0 : cnt_reg + 1'b1;
            default:
                cnt_next = '0;
        endcase
    end

    // operand selection and outputs
    always_comb
    begin
        num    = (state_reg == CALC_RAT_B) ? sums.background_passed_sum
                                           : sums.signal_passed_sum;
        den    = (state_reg == CALC_RAT_B) ? sums.background_sum : sums.signal_sum;
        unit_x = '0;
        unit_y = '0;
        mul_a  = '0;
        mul_b  = '0;
        done   = 1'b0;
        case (state_reg)
            CALC_RAT_S, CALC_RAT_B:
            begin
                unit_x = (cnt_reg == '0) ? {1'b0, num} : {r_reg[UNIT_BITS-2:0], 1'b0};
                unit_y = {1'b0, den};
            end
            CALC_DIV:
            begin
                unit_x = UNIT_BITS'({r_reg[REM_BITS-1:0], prod_reg[PROD_BITS-1]});
                unit_y = UNIT_BITS'(rem_reg);
            end
            CALC_SQRT:
            begin
                unit_x = {r_reg[UNIT_BITS-3:0], prod_reg[PROD_BITS-1 -: 2]};
                unit_y = UNIT_BITS'({q_reg[ROOT_BITS-1:0], 2'b01});
            end
            CALC_MUL_ES:
            begin
                mul_a = A_BITS'(es_reg);
                mul_b = MUL_B_BITS'(es_reg);
            end
            CALC_MUL_PE:
            begin
                mul_a = A_BITS'(photon_cross_section);
                mul_b = MUL_B_BITS'(eb_reg);
            end
            CALC_MUL_LO:
            begin
                mul_a = a_reg;
                mul_b = base_reg[MUL_B_BITS-1:0];
            end
            CALC_MUL_HI:
            begin
                mul_a = a_reg;
                mul_b = MUL_B_BITS'(base_reg[BASE_BITS-1:MUL_B_BITS]);
            end
            CALC_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CALC_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_p;
        case (state_reg)
            CALC_IDLE:
            begin
                if (ctrl.start)
                begin
                    status_reg <= STATUS_OK;
                    imp_reg    <= '0;
                end
            end
            CALC_CHECK:
            begin
                q_reg <= '0;
                if (empty)
                begin
                    es_reg     <= '0;
                    eb_reg     <= '0;
                    status_reg <= STATUS_EMPTY;
                end
            end
            CALC_RAT_S, CALC_RAT_B:
            begin
                r_reg <= r_next;
                q_reg <= q_shift;
                if (last_step)
                begin
                    q_reg <= '0;
                    if (state_reg == CALC_RAT_S)
                    begin
                        es_reg <= q_shift[EFF_BITS-1:0];
                    end
                    else
                    begin
                        eb_reg <= q_shift[EFF_BITS-1:0];
                    end
                end
            end
            CALC_MUL_PE:
            begin
                a_reg <= mul_reg[A_BITS-1:0];
            end
            CALC_REM:
            begin
                rem_reg  <= mul_reg[REM_BITS-1:0] +
                            REM_BITS'({dis_cross_section, {FRAC_BITS{1'b0}}});
                base_reg <= {(XS_BITS + 1)'(photon_cross_section) +
                             (XS_BITS + 1)'(dis_cross_section), {FRAC_BITS{1'b0}}};
            end
            CALC_MUL_LO:
            begin
                if (rem_zero)
                begin
                    status_reg <= STATUS_ZERO_DEN;
                end
            end
            CALC_MUL_HI:
            begin
                prod_reg <= PROD_BITS'(mul_reg);
            end
            CALC_SUM:
            begin
                prod_reg <= prod_reg + {mul_reg[PROD_BITS-MUL_B_BITS-1:0], {MUL_B_BITS{1'b0}}};
                r_reg    <= '0;
                q_reg    <= '0;
                sat_reg  <= 1'b0;
            end
            CALC_DIV:
            begin
                prod_reg <= {prod_reg[PROD_BITS-2:0], 1'b0};
                r_reg    <= r_next;
                q_reg    <= q_shift;
                sat_reg  <= sat_next;
                if (last_step)
                begin
                    if (sat_next)
                    begin
                        imp_reg <= IMPROVE_MAX;
                    end
                    else
                    begin
                        // load the square for the root, top bits first
                        prod_reg <= {q_shift[SQ_BITS-1:0], {(PROD_BITS - SQ_BITS){1'b0}}};
                        r_reg    <= '0;
                        q_reg    <= '0;
                    end
                end
            end
            CALC_SQRT:
            begin
                prod_reg <= {prod_reg[PROD_BITS-3:0], 2'b00};
                r_reg    <= r_next;
                q_reg    <= q_shift;
                if (last_step)
                begin
                    imp_reg <= q_shift[ROOT_BITS-1:0];
                end
            end
            default:
            begin
                r_reg <= r_reg;
            end
        endcase
    end

    always_comb
    begin
        result.signal_efficiency     = es_reg;
        result.background_efficiency = eb_reg;
        result.improvement           = imp_reg;
        result.status                = status_reg;
    end

endmodule
